### design/atpr_pkg.sv
// Package: shared constants, types and functions for the tilt block.
`default_nettype none
package atpr_pkg;
  localparam int CORDIC_STEPS = 16;
  localparam int STEPS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int SQ_W = 31;               // a^2+b^2 <= 2^31
  localparam int RT_W = 32;               // root of sq<<32 is below 2^32
  localparam int ROOT_STAGES = 32;        // one root bit per stage
  localparam int CW = 40;                 // CORDIC datapath width, signed
  localparam int AW = 24;                 // angle accumulator width, signed
  localparam int RIGHT_ANGLE_UNITS = 23040;
  localparam int RIGHT_ANGLE_ACC = 90 * 65536;

  function automatic logic signed [AW-1:0] atan_entry(input int i);
    logic signed [AW-1:0] v;
    begin
      case (i)
        0: v = 24'sd2949120;  1: v = 24'sd1740967; 2: v = 24'sd919879;
        3: v = 24'sd466945;   4: v = 24'sd234379;  5: v = 24'sd117304;
        6: v = 24'sd58666;    7: v = 24'sd29335;   8: v = 24'sd14668;
        9: v = 24'sd7334;     10: v = 24'sd3667;   11: v = 24'sd1833;
        12: v = 24'sd917;     13: v = 24'sd458;    14: v = 24'sd229;
        15: v = 24'sd115;     16: v = 24'sd57;     17: v = 24'sd29;
        18: v = 24'sd14;      19: v = 24'sd7;      20: v = 24'sd4;
        21: v = 24'sd2;       22: v = 24'sd1;      default: v = '0;
      endcase
      return v;
    end
  endfunction

  // Lane side-band carried along the pipeline.
  typedef struct packed {
    logic neg;
    logic zero_num;
  } lane_flags_t;
endpackage
`default_nettype wire

### design/atpr_lane.sv
// One lane: squares, pipelined square root, pipelined CORDIC vectoring, rounding.
`default_nettype none
module atpr_lane (
  input  wire logic                clk,
  input  wire logic signed [15:0]  num,
  input  wire logic signed [15:0]  a,
  input  wire logic signed [15:0]  b,
  output logic signed [15:0]       angle
);
  import atpr_pkg::*;
  localparam int RV = 64;

  logic [16:0]           mag_s0;
  logic                  neg_s0;
  logic [SQ_W-1:0]       asq, bsq;
  logic [RV-1:0]         rv   [0:ROOT_STAGES];
  logic [RV-1:0]         rr   [0:ROOT_STAGES];
  logic [16:0]           rmag [0:ROOT_STAGES];
  lane_flags_t           rfl  [0:ROOT_STAGES];
  logic signed [CW-1:0]  cx   [0:STEPS];
  logic signed [CW-1:0]  cy   [0:STEPS];
  logic signed [AW-1:0]  cacc [0:STEPS];
  lane_flags_t           cfl  [0:STEPS];
  logic                  cden0[0:STEPS];

  // Stage 0: magnitude and squares.
  always_ff @(posedge clk) begin
    neg_s0 <= num[15];
    mag_s0 <= num[15] ? 17'(-$signed({num[15], num})) : {1'b0, num};
    asq    <= SQ_W'(32'($signed(a) * $signed(a)));
    bsq    <= SQ_W'(32'($signed(b) * $signed(b)));
  end

  // Stage 1: sum; load root pipeline.
  always_ff @(posedge clk) begin
    rv[0]   <= {1'b0, ({1'b0, asq} + {1'b0, bsq})} << 32;
    rr[0]   <= '0;
    rmag[0] <= mag_s0;
    rfl[0]  <= '{neg: neg_s0, zero_num: (mag_s0 == '0)};
  end

  // Root stages: bit-pair restoring square root.
  for (genvar s = 0; s < ROOT_STAGES; s++) begin : g_root
    localparam logic [RV-1:0] BIT = RV'(1) << (2 * (31 - s));
    logic [RV-1:0] trial;
    assign trial = rr[s] + BIT;
    always_ff @(posedge clk) begin
      if (rv[s] >= trial) begin
        rv[s+1] <= rv[s] - trial;
        rr[s+1] <= (rr[s] >> 1) + BIT;
      end else begin
        rv[s+1] <= rv[s];
        rr[s+1] <= rr[s] >> 1;
      end
      rmag[s+1] <= rmag[s];
      rfl[s+1]  <= rfl[s];
    end
  end

  assign cx[0]    = CW'(rr[ROOT_STAGES][RT_W-1:0]);
  assign cy[0]    = CW'({rmag[ROOT_STAGES], 16'h0000});
  assign cacc[0]  = '0;
  assign cfl[0]   = rfl[ROOT_STAGES];
  assign cden0[0] = (rr[ROOT_STAGES] == '0);

  // CORDIC micro-rotations, one per stage.
  for (genvar i = 0; i < STEPS; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (!cy[i][CW-1]) begin
        cx[i+1]   <= cx[i] + (cy[i] >>> i);
        cy[i+1]   <= cy[i] - (cx[i] >>> i);
        cacc[i+1] <= cacc[i] + atan_entry(i);
      end else begin
        cx[i+1]   <= cx[i] - (cy[i] >>> i);
        cy[i+1]   <= cy[i] + (cx[i] >>> i);
        cacc[i+1] <= cacc[i] - atan_entry(i);
      end
      cfl[i+1]   <= cfl[i];
      cden0[i+1] <= cden0[i];
    end
  end

  // Output: clamp, round, sign.
  logic signed [AW-1:0] accc;
  logic [15:0]          res;
  logic [AW-1:0]        rnd;
  always_comb begin
    accc = cacc[STEPS];
    if (accc < 0) accc = '0;
    if (accc > AW'(RIGHT_ANGLE_ACC)) accc = AW'(RIGHT_ANGLE_ACC);
    rnd = (AW'(accc) + AW'(128)) >> 8;
    res = 16'(rnd);
    if (rnd > AW'(RIGHT_ANGLE_UNITS)) res = 16'(RIGHT_ANGLE_UNITS);
    if (cden0[STEPS]) res = 16'(RIGHT_ANGLE_UNITS);
    if (cfl[STEPS].zero_num) res = '0;
  end

  always_ff @(posedge clk) begin
    angle <= cfl[STEPS].neg ? -$signed(res) : $signed(res);
  end
endmodule
`default_nettype wire

### design/accel_tilt_pitch_roll.sv
// Top level: accelerometer pitch/roll, two parallel lanes and a result merge.
// Usage:
//   Drive accel_x/y/z and pulse start; busy is always low, so a transaction
//   is taken every cycle the caller raises start.
//   Each sample runs down two identical lanes side by side: the pitch lane
//   (x against the y-z magnitude) and the roll lane (y against x-z).
//   A lane is a squares register, a sum register, a 32-stage square-root pipe
//   (one root bit a stage), CORDIC_STEPS micro-rotation stages and one
//   rounding register. The merge joins both angles on done.
//   Throughput: one sample per cycle, set by the fully pipelined lanes.
//   done is high for exactly one cycle with pitch_angle and roll_angle; the
//   receiver cannot stall, so results are never held back.
//   Reset clears the valid pipe only; data in flight is dropped.
`default_nettype none
module accel_tilt_pitch_roll (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] accel_x,
  input  wire logic signed [15:0] accel_y,
  input  wire logic signed [15:0] accel_z,
  output logic                    done,
  output logic signed [15:0]      pitch_angle,
  output logic signed [15:0]      roll_angle
);
  import atpr_pkg::*;
  localparam int LAT = 2 + ROOT_STAGES + STEPS + 1;

  logic [LAT-1:0] vpipe;
  logic           accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Pitch lane and roll lane.
  atpr_lane u_pitch (.clk(clk), .num(accel_x), .a(accel_y),
                     .b(accel_z), .angle(pitch_angle));
  atpr_lane u_roll  (.clk(clk), .num(accel_y), .a(accel_x),
                     .b(accel_z), .angle(roll_angle));

  // Advance the valid marker alongside the lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LAT-2:0], accept};
    end
  end

  assign done = vpipe[LAT-1];

  a_range_p: assert property (@(posedge clk) disable iff (rst)
    done |-> (pitch_angle <= 16'sd23040 && pitch_angle >= -16'sd23040));
  a_range_r: assert property (@(posedge clk) disable iff (rst)
    done |-> (roll_angle <= 16'sd23040 && roll_angle >= -16'sd23040));
  a_lat: assert property (@(posedge clk) disable iff (rst)
    $past(vpipe[LAT-2]) |-> done) else $error("done lost");
endmodule
`default_nettype wire
